>>> rtl/wmci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard matcher package
// Shared types, codes and the case folding helper of the wildcard matcher.
// ----------------------------------------------------------------------------
package wmci_pkg;

  // Meaning of the mode field of an input beat.
  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_NAME    = 1'b1;

  // Pattern bytes with a special meaning.
  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] QUERY_CHAR = 8'h3F;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;

  // Bounds of the lower-case ASCII letters and the distance to upper case.
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic       step;   // a name beat advances the active set
    logic       run;    // the name run continues from the stored set
    logic [7:0] chr;    // case-folded input byte
    logic       star;   // the raw input byte is a star
    logic       query;  // the raw input byte is a question mark
  } ctl_t;

  // Signals that each cell hands to its right neighbor.
  typedef struct packed {
    logic adv;     // this position matched and activates the next one
    logic prop;    // an active star activates the next position for free
    logic pfx_wr;  // this position was just written
    logic pfx;     // every pattern byte up to and including this one is a star
  } link_t;

  // Upper-case an ASCII letter; other bytes pass unchanged.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= LOWER_A && c <= LOWER_Z) begin
      r = c - CASE_SHIFT;
    end
    return r;
  endfunction

endpackage

>>> rtl/wmci_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard matcher cell
// Holds one pattern byte and its bit of the active position set, and steps
// that bit for each name byte together with its neighbors.
// ----------------------------------------------------------------------------
module wmci_cell
  import wmci_pkg::*;
(
  input  logic  clk_i,
  input  ctl_t  ctl_i,
  input  logic  wr_en_i,
  input  logic  en_i,
  input  link_t link_i,
  output link_t link_o,
  output logic  hit_o
);

  logic [7:0] fold_q;
  logic       star_q;
  logic       query_q;
  logic       pfx_q;
  logic       act_q;

  logic active;
  logic hold;
  logic closed;

  // Pattern byte storage, kept folded with its wildcard flags.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      fold_q  <= ctl_i.chr;
      star_q  <= ctl_i.star;
      query_q <= ctl_i.query;
    end
    if (link_i.pfx_wr) begin
      pfx_q <= link_i.pfx;
    end
    if (ctl_i.step) begin
      act_q <= closed;
    end
  end

  // A fresh name starts from the star prefix; a running one from the stored set.
  assign active = ctl_i.run ? act_q : pfx_q;

  // Step this position: a star holds, a match moves one position right.
  assign hold       = active & en_i & star_q;
  assign link_o.adv = active & en_i & ~star_q & (query_q | (fold_q == ctl_i.chr));

  // Close the new set over stars, rippling from the left.
  assign closed      = hold | link_i.adv | link_i.prop;
  assign link_o.prop = closed & en_i & star_q;
  assign hit_o       = closed;

  // Star prefix for the next position, written along with this byte.
  assign link_o.pfx_wr = wr_en_i;
  assign link_o.pfx    = pfx_q & ctl_i.star;

endmodule

>>> rtl/wildcard_match_case_insensitive_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Case-insensitive wildcard matcher
// Stores a wildcard pattern and matches streamed names against it.
// ----------------------------------------------------------------------------
// The block takes one beat per clock, pattern bytes and name bytes alike,
// and keeps that rate while results flow out. Each pattern byte sits in a
// cell of a row of PATTERN_MAX cells; each name byte steps the whole active
// position set at once, with star closure rippling through the row inside
// that single cycle, which sets the clock period. The result of a name shows
// on the output in the cycle after its last byte is accepted. Input is held off
// only while a result waits and the output is stalled. There is no clearing
// pass after reset; the block is ready at once.
module wildcard_match_case_insensitive_core
  import wmci_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] character_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       pattern_overflow_o
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PATTERN_MAX);
  localparam logic [LEN_W-1:0] ONE_LEN = LEN_W'(1);

  logic [LEN_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             inprog_q, inprog_d;
  logic             run_q, run_d;
  logic             dot_q;
  logic             out_valid_q, out_valid_d;
  logic             matched_q;
  logic             povf_q;

  logic             in_fire;
  logic             pat_beat;
  logic             name_beat;
  logic [LEN_W-1:0] eff_len;
  logic             wr;
  logic             res_match;
  ctl_t             ctl;

  logic [PATTERN_MAX-1:0] wr_sel;
  logic [PATTERN_MAX-1:0] en;
  logic [PATTERN_MAX:0]   hits;
  link_t                  link [PATTERN_MAX+1];

  // Input handshake: hold off only while a result is stuck at the output.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign pat_beat   = in_fire & (mode_i == MODE_PATTERN);
  assign name_beat  = in_fire & (mode_i == MODE_NAME);

  // A pattern beat outside an open pattern starts a new one at position zero.
  assign eff_len = inprog_q ? len_q : '0;
  assign wr      = pat_beat & (eff_len < MAX_LEN);

  // Broadcast to the cells.
  assign ctl.step  = name_beat;
  assign ctl.run   = run_q;
  assign ctl.chr   = fold_case(character_i);
  assign ctl.star  = (character_i == STAR_CHAR);
  assign ctl.query = (character_i == QUERY_CHAR);

  // The first cell always sees an all-star prefix and nothing from its left.
  assign link[0] = '{adv: 1'b0, prop: 1'b0, pfx_wr: 1'b1, pfx: 1'b1};

  // Row of cells.
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    localparam logic [LEN_W-1:0] IDX = LEN_W'(i);

    assign wr_sel[i] = wr & (eff_len == IDX);
    assign en[i]     = (IDX < len_q);

    wmci_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .wr_en_i (wr_sel[i]),
      .en_i    (en[i]),
      .link_i  (link[i]),
      .link_o  (link[i+1]),
      .hit_o   (hits[i])
    );
  end

  // The position past a full store has no cell of its own.
  assign hits[PATTERN_MAX] = link[PATTERN_MAX].adv | link[PATTERN_MAX].prop;

  // Result of a name: overflow wins, then the lone dot, then the end position.
  always_comb begin
    if (ovf_q) begin
      res_match = 1'b0;
    end else if (len_q == ONE_LEN && dot_q) begin
      res_match = 1'b1;
    end else begin
      res_match = hits[len_q];
    end
  end

  // Pattern length, overflow and run tracking.
  always_comb begin
    len_d    = len_q;
    ovf_d    = ovf_q;
    inprog_d = inprog_q;
    run_d    = run_q;
    if (pat_beat) begin
      ovf_d = inprog_q ? ovf_q : 1'b0;
      if (eff_len < MAX_LEN) begin
        len_d = eff_len + ONE_LEN;
      end else begin
        len_d = eff_len;
        ovf_d = 1'b1;
      end
      inprog_d = ~last_i;
      run_d    = 1'b0;
    end else if (name_beat) begin
      inprog_d = ~last_i;
      run_d    = ~last_i;
    end
  end

  // Output register: loaded by the last name beat, freed when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (name_beat && last_i) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      inprog_q    <= 1'b0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      inprog_q    <= inprog_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload and the lone-dot flag of the first pattern byte.
  always_ff @(posedge clk_i) begin
    if (name_beat && last_i) begin
      matched_q <= res_match;
      povf_q    <= ovf_q;
    end
    if (wr_sel[0]) begin
      dot_q <= (character_i == DOT_CHAR);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = povf_q;

endmodule

>>> rtl/wmci_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard matcher checker
// Port-level properties of the wildcard matcher, bound to the top level.
// ----------------------------------------------------------------------------
module wmci_checker
  import wmci_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       mode_i,
  input logic [7:0] character_i,
  input logic       last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       matched_o,
  input logic       pattern_overflow_o
);

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(matched_o)
      && $stable(pattern_overflow_o))
    else $error("stalled result beat changed");

  // An overflowed pattern never matches.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pattern_overflow_o |-> !matched_o)
    else $error("match reported with pattern overflow");

  // The last name beat always yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i == MODE_NAME && last_i |=> out_valid_o)
    else $error("missing result after last name beat");

  // A new result only follows the last beat of a name.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && mode_i == MODE_NAME
      && last_i))
    else $error("result without a finished name");

endmodule

bind wildcard_match_case_insensitive_core wmci_checker u_wmci_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .mode_i             (mode_i),
  .character_i        (character_i),
  .last_i             (last_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .matched_o          (matched_o),
  .pattern_overflow_o (pattern_overflow_o)
);

>>> test/tb_wildcard_match_case_insensitive_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench of the case-insensitive wildcard matcher
// Loads patterns and streams names through the core under random idling on
// both channels. Every result beat is checked against its hand-written verdict
// if any, else a behavioral matcher tracking the pattern and live position set.
// ----------------------------------------------------------------------------
module tb_wildcard_match_case_insensitive_core;
  import wmci_pkg::*;

  localparam int PAT_MAX     = 32;
  localparam int RAND_BEATS  = 950;
  localparam int CYCLE_LIMIT = 400000;

  // One input beat, with an optional hand-written verdict.
  typedef struct {
    logic       md;
    logic [7:0] ch;
    logic       lst;
    bit         typed;
    logic       em;
    logic       eo;
  } beat_t;

  // One row of the directed table; reps repeats the beat.
  typedef struct packed {
    logic       md;
    logic [7:0] ch;
    logic       lst;
    logic [5:0] reps;
    logic       typed;
    logic       em;
    logic       eo;
  } dir_row_t;

  typedef struct {
    logic m;
    logic o;
  } verdict_t;

  localparam int DIR_ROWS = 32;

  // Directed table: empty pattern, the dot pattern, wildcards, extreme bytes,
  // a name cutting a pattern short, a pattern byte cutting a name short,
  // and a pattern one byte too long followed by a fresh pattern.
  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{MODE_NAME,    8'h41,      1'b1, 6'd1,  1'b1, 1'b0, 1'b0},
    '{MODE_PATTERN, DOT_CHAR,   1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h78,      1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    STAR_CHAR,  1'b1, 6'd1,  1'b1, 1'b1, 1'b0},
    '{MODE_PATTERN, 8'h61,      1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_PATTERN, QUERY_CHAR, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_PATTERN, STAR_CHAR,  1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_PATTERN, 8'h5A,      1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h41,      1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    QUERY_CHAR, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h7A,      1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h61,      1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h00,      1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'hFF,      1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h5A,      1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h62,      1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_PATTERN, 8'hFF,      1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_PATTERN, 8'h00,      1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'hFF,      1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h00,      1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_PATTERN, 8'h62,      1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h42,      1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_PATTERN, 8'h63,      1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h63,      1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_PATTERN, 8'h64,      1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h63,      1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h44,      1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_PATTERN, STAR_CHAR,  1'b0, 6'd32, 1'b0, 1'b0, 1'b0},
    '{MODE_PATTERN, STAR_CHAR,  1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h71,      1'b1, 6'd1,  1'b1, 1'b0, 1'b1},
    '{MODE_PATTERN, 8'h71,      1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
    '{MODE_NAME,    8'h51,      1'b1, 6'd1,  1'b0, 1'b0, 1'b0}
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       mode_i      = MODE_PATTERN;
  logic [7:0] character_i = 8'h00;
  logic       last_i      = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       matched_o;
  logic       pattern_overflow_o;

  // Hand-written verdict travelling with the beat on the input port.
  logic cur_typed = 1'b0;
  logic cur_em    = 1'b0;
  logic cur_eo    = 1'b0;

  beat_t    stim_q [$];
  verdict_t verdict_q [$];
  int       errors = 0;
  int       cycles = 0;

  // State of the behavioral matcher.
  logic [7:0]     pat_bytes [PAT_MAX];
  int             pat_len      = 0;
  logic [PAT_MAX:0] live_pos   = '0;
  logic           pat_overflow = 1'b0;
  logic           run_busy     = 1'b0;

  always #1 clk_i = ~clk_i;

  wildcard_match_case_insensitive_core #(
    .PATTERN_MAX(PAT_MAX)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .character_i        (character_i),
    .last_i             (last_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .matched_o          (matched_o),
    .pattern_overflow_o (pattern_overflow_o)
  );

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // A live star also makes the position after it live; one pass from the
  // left covers chains of stars.
  function automatic logic [PAT_MAX:0] star_close(input logic [PAT_MAX:0] s);
    logic [PAT_MAX:0] r;
    r = s;
    for (int i = 0; i < pat_len; i++) begin
      if (r[i] && pat_bytes[i] == STAR_CHAR) begin
        r[i + 1] = 1'b1;
      end
    end
    return r;
  endfunction

  // Applies one accepted beat; returns 1 when the beat yields a verdict.
  function automatic bit step_matcher(input logic md, input logic [7:0] ch,
                                      input logic lst, output logic m,
                                      output logic o);
    logic [PAT_MAX:0] nxt;
    m = 1'b0;
    o = 1'b0;
    if (md == MODE_PATTERN) begin
      if (!run_busy) begin
        pat_len      = 0;
        pat_overflow = 1'b0;
      end
      if (pat_len < PAT_MAX) begin
        pat_bytes[pat_len] = ch;
        pat_len++;
      end else begin
        pat_overflow = 1'b1;
      end
      run_busy = !lst;
      live_pos = star_close({{PAT_MAX{1'b0}}, 1'b1});
      return 1'b0;
    end
    if (!run_busy) begin
      live_pos = star_close({{PAT_MAX{1'b0}}, 1'b1});
    end
    nxt = '0;
    for (int i = 0; i < pat_len; i++) begin
      if (live_pos[i]) begin
        if (pat_bytes[i] == STAR_CHAR) begin
          nxt[i] = 1'b1;
        end else if (pat_bytes[i] == QUERY_CHAR || upcase(pat_bytes[i]) == upcase(ch)) begin
          nxt[i + 1] = 1'b1;
        end
      end
    end
    live_pos = star_close(nxt);
    run_busy = !lst;
    if (!lst) begin
      return 1'b0;
    end
    o = pat_overflow;
    m = !pat_overflow &&
        ((pat_len == 1 && pat_bytes[0] == DOT_CHAR) || live_pos[pat_len]);
    return 1'b1;
  endfunction

  task automatic add_beat(input logic md, input logic [7:0] ch, input logic lst);
    beat_t b;
    b.md    = md;
    b.ch    = ch;
    b.lst   = lst;
    b.typed = 1'b0;
    b.em    = 1'b0;
    b.eo    = 1'b0;
    stim_q.push_back(b);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'h41 + 8'($urandom_range(0, 4));
    if ($urandom_range(0, 1) == 1) begin
      c = c | 8'h20;
    end
    return c;
  endfunction

  // Pattern bytes lean toward wildcards and a few letters so names match.
  function automatic logic [7:0] rand_sym();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1:    c = STAR_CHAR;
      2:       c = QUERY_CHAR;
      3:       c = DOT_CHAR;
      4:       c = 8'($urandom_range(0, 255));
      default: c = rand_letter();
    endcase
    return c;
  endfunction

  // Flips the case of a letter now and then.
  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1) == 1) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  // Random part: patterns followed by names derived from them, with some
  // mutated names, some cut short by a pattern byte, and raw noise beats.
  task automatic build_random(input int target);
    logic [7:0] pat [$];
    logic [7:0] nm [$];
    int         plen;
    int         n;
    bit         cut;
    while (stim_q.size() < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          add_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
        end
        continue;
      end
      pat.delete();
      if ($urandom_range(0, 14) == 0) begin
        pat.push_back(DOT_CHAR);
      end else begin
        plen = ($urandom_range(0, 24) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 8);
        repeat (plen) pat.push_back(rand_sym());
      end
      // Sometimes the first name beat ends the pattern instead of last.
      cut = ($urandom_range(0, 9) == 0);
      foreach (pat[k]) begin
        add_beat(MODE_PATTERN, pat[k], (k == pat.size() - 1) && !cut);
      end
      repeat ($urandom_range(1, 5)) begin
        nm.delete();
        foreach (pat[k]) begin
          if (pat[k] == STAR_CHAR) begin
            repeat ($urandom_range(0, 3)) nm.push_back(rand_letter());
          end else if (pat[k] == QUERY_CHAR) begin
            nm.push_back(8'($urandom_range(0, 255)));
          end else begin
            nm.push_back(mix_case(pat[k]));
          end
        end
        if ($urandom_range(0, 2) == 0 && nm.size() != 0) begin
          nm[$urandom_range(0, nm.size() - 1)] = rand_letter();
        end
        if ($urandom_range(0, 5) == 0 || nm.size() == 0) begin
          nm.push_back(rand_letter());
        end
        if ($urandom_range(0, 11) == 0) begin
          n = $urandom_range(1, nm.size());
          for (int j = 0; j < n; j++) begin
            add_beat(MODE_NAME, nm[j], 1'b0);
          end
          add_beat(MODE_PATTERN, rand_sym(), 1'($urandom_range(0, 1)));
        end else begin
          foreach (nm[j]) begin
            add_beat(MODE_NAME, nm[j], j == nm.size() - 1);
          end
        end
      end
    end
  endtask

  // Predict on every accepted input beat.
  always @(posedge clk_i) begin : accept_mon
    logic     m;
    logic     o;
    verdict_t v;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (step_matcher(mode_i, character_i, last_i, m, o)) begin
        v.m = cur_typed ? cur_em : m;
        v.o = cur_typed ? cur_eo : o;
        verdict_q.push_back(v);
      end
    end
  end

  // Compare every accepted result beat with the oldest verdict.
  always @(posedge clk_i) begin : verdict_check
    verdict_t v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with no verdict pending");
        errors++;
      end else begin
        v = verdict_q.pop_front();
        if (matched_o !== v.m) begin
          $error("matched: expected %0b, got %0b", v.m, matched_o);
          errors++;
        end
        if (pattern_overflow_o !== v.o) begin
          $error("pattern_overflow: expected %0b, got %0b", v.o, pattern_overflow_o);
          errors++;
        end
      end
    end
  end

  // Receiver stall: switches between quiet, light, heavy and near-constant.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sender: builds the stimulus, then drives it in bursts with gaps.
  initial begin : drive_proc
    beat_t b;
    int    burst;
    int    gap;
    foreach (dir_tbl[r]) begin
      repeat (dir_tbl[r].reps) begin
        b.md    = dir_tbl[r].md;
        b.ch    = dir_tbl[r].ch;
        b.lst   = dir_tbl[r].lst;
        b.typed = dir_tbl[r].typed;
        b.em    = dir_tbl[r].em;
        b.eo    = dir_tbl[r].eo;
        stim_q.push_back(b);
      end
    end
    build_random(stim_q.size() + RAND_BEATS);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst = 0;
    while (stim_q.size() != 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      b = stim_q.pop_front();
      in_valid_i  <= 1'b1;
      mode_i      <= b.md;
      character_i <= b.ch;
      last_i      <= b.lst;
      cur_typed   <= b.typed;
      cur_em      <= b.em;
      cur_eo      <= b.eo;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      burst--;
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding verdicts, then allow for the output latency.
    @(posedge clk_i);
    wait (verdict_q.size() == 0);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
